>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GNE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gne assertion failed");

// next-cycle implication
`define GNE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gne assertion failed");

`endif

>>> rtl/core/gne_pkg.sv
// ----------------------------------------------------------------------------
// gne_pkg
// constants, offset tables and helpers for the grid neighbor enumerator
// ----------------------------------------------------------------------------
package gne_pkg;

   localparam int MAX_DIM     = 256;
   localparam int DIM_W       = $clog2(MAX_DIM + 1);
   localparam int COORD_W     = 8;
   localparam int INDEX_W     = 16;
   localparam int CSR_W       = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int NUM_OFF     = 8;
   localparam int OFF_IDX_W   = $clog2(NUM_OFF);
   localparam int CAND_W      = COORD_W + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_RECT = 2'd0;
   localparam logic [1:0] KIND_HEX  = 2'd1;
   localparam logic [1:0] KIND_OCT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KIND   = 2'd2;

   localparam logic signed [1:0] RECT_DX [NUM_OFF] =
      '{2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0};
   localparam logic signed [1:0] RECT_DY [NUM_OFF] =
      '{2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0};
   localparam logic signed [1:0] HEX_DX [NUM_OFF] =
      '{2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0};
   localparam logic signed [1:0] HEX_DY [NUM_OFF] =
      '{2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0};
   localparam logic signed [1:0] OCT_DX [NUM_OFF] =
      '{-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1};
   localparam logic signed [1:0] OCT_DY [NUM_OFF] =
      '{2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1};

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [1:0]       kind;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [1:0]         kind;
      logic [NUM_OFF-1:0] mask;
   } task_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_W-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide > 32'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(wide);
   endfunction

   function automatic logic signed [1:0] off_dx(input logic [1:0] kind,
                                                input logic [OFF_IDX_W-1:0] pos);
      logic signed [1:0] d;
      case (kind)
         KIND_RECT: d = RECT_DX[pos];
         KIND_HEX:  d = HEX_DX[pos];
         KIND_OCT:  d = OCT_DX[pos];
         default:   d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] off_dy(input logic [1:0] kind,
                                                input logic [OFF_IDX_W-1:0] pos);
      logic signed [1:0] d;
      case (kind)
         KIND_RECT: d = RECT_DY[pos];
         KIND_HEX:  d = HEX_DY[pos];
         KIND_OCT:  d = OCT_DY[pos];
         default:   d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic [OFF_IDX_W:0] off_count(input logic [1:0] kind);
      logic [OFF_IDX_W:0] n;
      case (kind)
         KIND_RECT: n = (OFF_IDX_W+1)'(4);
         KIND_HEX:  n = (OFF_IDX_W+1)'(6);
         KIND_OCT:  n = (OFF_IDX_W+1)'(8);
         default:   n = '0;
      endcase
      return n;
   endfunction

   // coordinate plus offset, kept with a sign bit and a carry bit
   function automatic logic [CAND_W-1:0] cand_ext(input logic [COORD_W-1:0] p,
                                                  input logic signed [1:0] d);
      return {2'b00, p} + {{(CAND_W-2){d[1]}}, d};
   endfunction

   function automatic logic cand_in(input logic [CAND_W-1:0] c,
                                    input logic [DIM_W-1:0] lim);
      return !c[CAND_W-1] && (c[CAND_W-2:0] < lim);
   endfunction

   function automatic logic [COORD_W-1:0] cand_coord(input logic [COORD_W-1:0] p,
                                                     input logic signed [1:0] d);
      return p + {{(COORD_W-2){d[1]}}, d};
   endfunction

endpackage

>>> rtl/core/gne_if.sv
// ----------------------------------------------------------------------------
// gne channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface gne_req_if;
   logic                        valid;
   logic                        ready;
   logic [gne_pkg::COORD_W-1:0] point_x;
   logic [gne_pkg::COORD_W-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface gne_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gne_pkg::COORD_W-1:0] neighbor_x;
   logic [gne_pkg::COORD_W-1:0] neighbor_y;
   logic [gne_pkg::INDEX_W-1:0] neighbor_index;
   logic                        last_neighbor;

   modport source (output valid, output neighbor_x, output neighbor_y,
                   output neighbor_index, output last_neighbor, input ready);
   modport sink   (input valid, input neighbor_x, input neighbor_y,
                   input neighbor_index, input last_neighbor, output ready);
endinterface

>>> rtl/core/gne_front.sv
// ----------------------------------------------------------------------------
// gne_front
// accepts a cell word and builds the mask of on-grid neighbor offsets
// ----------------------------------------------------------------------------
module gne_front (
   gne_req_if.sink             req_chan,
   input  gne_pkg::cfg_type    cfg,
   input  logic                q_full,
   output logic                push,
   output gne_pkg::task_type   push_task
);

   logic [gne_pkg::NUM_OFF-1:0]   mask;
   logic [gne_pkg::OFF_IDX_W:0]   count;

   always_comb begin
      count = gne_pkg::off_count(cfg.kind);
      for (int i = 0; i < gne_pkg::NUM_OFF; i++) begin
         mask[i] = ((gne_pkg::OFF_IDX_W+1)'(i) < count)
            && gne_pkg::cand_in(gne_pkg::cand_ext(req_chan.point_x,
                  gne_pkg::off_dx(cfg.kind, gne_pkg::OFF_IDX_W'(i))), cfg.width)
            && gne_pkg::cand_in(gne_pkg::cand_ext(req_chan.point_y,
                  gne_pkg::off_dy(cfg.kind, gne_pkg::OFF_IDX_W'(i))), cfg.height);
      end
   end

   assign req_chan.ready = !q_full;

   // words with no on-grid neighbor are dropped here
   assign push           = req_chan.valid && !q_full && (|mask);
   assign push_task.px   = req_chan.point_x;
   assign push_task.py   = req_chan.point_y;
   assign push_task.kind = cfg.kind;
   assign push_task.mask = mask;

endmodule

>>> rtl/core/gne_queue.sv
// ----------------------------------------------------------------------------
// gne_queue
// short fifo between the classify front and the enumerate back
// ----------------------------------------------------------------------------
module gne_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gne_pkg::task_type   push_task,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output gne_pkg::task_type   head_task
);

   gne_pkg::task_type               entry_ff [gne_pkg::QUEUE_DEPTH];
   logic [gne_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [gne_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [gne_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full       = (count_ff == gne_pkg::QCNT_W'(gne_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_task  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == gne_pkg::QPTR_W'(gne_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == gne_pkg::QPTR_W'(gne_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_task;
      end
   end

endmodule

>>> rtl/core/gne_back.sv
// ----------------------------------------------------------------------------
// gne_back
// walks the mask one neighbor a cycle unless stalled; forms the linear index
// ----------------------------------------------------------------------------
module gne_back (
   input  logic                clock,
   input  logic                reset,
   input  gne_pkg::cfg_type    cfg,
   input  logic                head_valid,
   input  gne_pkg::task_type   head_task,
   output logic                pop,
   gne_rsp_if.source           rsp_chan
);

   logic [gne_pkg::NUM_OFF-1:0]   used_ff, used_in;
   logic [gne_pkg::NUM_OFF-1:0]   rem, rem_after, sel_bit;
   logic [gne_pkg::OFF_IDX_W-1:0] sel;
   logic                          sel_last;
   logic                          take;
   logic                          s1_adv;
   logic                          out_adv;

   logic                          s1_valid_ff, s1_valid_in;
   logic [gne_pkg::COORD_W-1:0]   s1_x_ff, s1_y_ff;
   logic                          s1_last_ff;

   logic                          out_valid_ff, out_valid_in;
   logic [gne_pkg::COORD_W-1:0]   out_x_ff, out_y_ff;
   logic [gne_pkg::INDEX_W-1:0]   out_index_ff, out_index_in;
   logic                          out_last_ff;

   always_comb begin
      rem = head_task.mask & ~used_ff;
      sel = '0;
      for (int i = gne_pkg::NUM_OFF - 1; i >= 0; i--) begin
         if (rem[i]) begin
            sel = gne_pkg::OFF_IDX_W'(i);
         end
      end
      sel_bit   = gne_pkg::NUM_OFF'(1) << sel;
      rem_after = rem & ~sel_bit;
      sel_last  = (rem_after == '0);
   end

   assign out_adv = !out_valid_ff || rsp_chan.ready;
   assign s1_adv  = !s1_valid_ff || out_adv;
   assign take    = head_valid && s1_adv;
   assign pop     = take && sel_last;

   always_comb begin
      used_in = used_ff;
      if (take) begin
         used_in = sel_last ? '0 : (used_ff | sel_bit);
      end
      s1_valid_in  = s1_adv ? take : s1_valid_ff;
      out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;
      out_index_in = gne_pkg::INDEX_W'(32'(s1_x_ff) + 32'(s1_y_ff) * 32'(cfg.width));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_x_ff    <= gne_pkg::cand_coord(head_task.px,
                          gne_pkg::off_dx(head_task.kind, sel));
         s1_y_ff    <= gne_pkg::cand_coord(head_task.py,
                          gne_pkg::off_dy(head_task.kind, sel));
         s1_last_ff <= sel_last;
      end
      if (out_adv) begin
         out_x_ff     <= s1_x_ff;
         out_y_ff     <= s1_y_ff;
         out_index_ff <= out_index_in;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.neighbor_x     = out_x_ff;
   assign rsp_chan.neighbor_y     = out_y_ff;
   assign rsp_chan.neighbor_index = out_index_ff;
   assign rsp_chan.last_neighbor  = out_last_ff;

endmodule

>>> rtl/core/grid_neighbor_enumerator.sv
// ----------------------------------------------------------------------------
// grid_neighbor_enumerator
// emits the on-grid neighbors of a cell for 4-, 6- or 8-way connectivity
// ----------------------------------------------------------------------------
//  port       dir   role
//  req_chan   in    cell word: point_x, point_y
//  rsp_chan   out   neighbor word: x, y, linear index, last flag
//  csr_*      in    register writes: width, height, connectivity
//
//  a cell word is classified combinationally in the front; the back then sends
//  one neighbor word per cycle unless the output stalls, one for each on-grid
//  neighbor (4, 6 or 8 at most, none for a cell with no neighbor on the grid)
//  the first neighbor word of a cell passes the queue, stage-one and output registers
//  reset clears the queue and the pipeline and loads width 256, height 256, 4-way
//  either side may stall; a two-entry queue and the output register decouple them
// ----------------------------------------------------------------------------
module grid_neighbor_enumerator (
   input  logic                            clock,
   input  logic                            reset,
   gne_req_if.sink                         req_chan,
   gne_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [gne_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gne_pkg::CSR_W-1:0]       csr_wdata
);

   gne_pkg::cfg_type    cfg_ff;
   gne_pkg::task_type   push_task;
   gne_pkg::task_type   head_task;
   logic                push;
   logic                pop;
   logic                q_full;
   logic                head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= gne_pkg::DIM_W'(gne_pkg::MAX_DIM);
         cfg_ff.height <= gne_pkg::DIM_W'(gne_pkg::MAX_DIM);
         cfg_ff.kind   <= gne_pkg::KIND_RECT;
      end else if (csr_we) begin
         case (csr_index)
            gne_pkg::CSR_WIDTH:  cfg_ff.width  <= gne_pkg::clamp_dim(csr_wdata);
            gne_pkg::CSR_HEIGHT: cfg_ff.height <= gne_pkg::clamp_dim(csr_wdata);
            gne_pkg::CSR_KIND:   cfg_ff.kind   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   gne_front u_front (
      .req_chan  (req_chan),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .push_task (push_task)
   );

   gne_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_task  (push_task),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_task  (head_task)
   );

   gne_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_task  (head_task),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> rtl/core/gne_checker.sv
// ----------------------------------------------------------------------------
// gne_checker
// port-level checks on the neighbor enumerator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gne_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [gne_pkg::COORD_W-1:0]     nx,
   input  logic [gne_pkg::COORD_W-1:0]     ny,
   input  logic [gne_pkg::INDEX_W-1:0]     nidx,
   input  logic                            nlast,
   input  logic                            csr_we,
   input  logic [gne_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gne_pkg::CSR_W-1:0]       csr_wdata
);

   logic [gne_pkg::DIM_W-1:0]   shadow_w_ff;
   logic [gne_pkg::DIM_W-1:0]   shadow_h_ff;
   logic [gne_pkg::INDEX_W-1:0] exp_idx;

   // width and height as last written on the register port
   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_w_ff <= gne_pkg::DIM_W'(gne_pkg::MAX_DIM);
         shadow_h_ff <= gne_pkg::DIM_W'(gne_pkg::MAX_DIM);
      end else if (csr_we) begin
         if (csr_index == gne_pkg::CSR_WIDTH) begin
            shadow_w_ff <= gne_pkg::clamp_dim(csr_wdata);
         end
         if (csr_index == gne_pkg::CSR_HEIGHT) begin
            shadow_h_ff <= gne_pkg::clamp_dim(csr_wdata);
         end
      end
   end

   assign exp_idx = gne_pkg::INDEX_W'(32'(nx) + 32'(ny) * 32'(shadow_w_ff));

   `GNE_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && req_ready)
   `GNE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(nx) && $stable(ny) && $stable(nidx) && $stable(nlast))
   `GNE_ASSERT_IMP(a_on_grid, clock, reset, rsp_valid,
      (nx < shadow_w_ff) && (ny < shadow_h_ff))
   `GNE_ASSERT_IMP(a_index, clock, reset, rsp_valid, nidx == exp_idx)

endmodule

bind grid_neighbor_enumerator gne_checker u_gne_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .nx        (rsp_chan.neighbor_x),
   .ny        (rsp_chan.neighbor_y),
   .nidx      (rsp_chan.neighbor_index),
   .nlast     (rsp_chan.last_neighbor),
   .csr_we    (csr_we),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);
